>>> rtl/teas_pkg.sv
// Shared types and constants for the triangle edge adjacency search.
// No dependencies; used by the interfaces, front end, search engine, top level and checker.
package teas_pkg;

    localparam int MAX_TRIANGLES_DEF  = 1024;
    localparam int VERTEX_ID_BITS_DEF = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 10;
    localparam int VTX_W   = 16;
    localparam int COUNT_W = 11;

    localparam logic [FUNC_W-1:0] FUNC_WRITE    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EDGE     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_NEIGHBOR = 2'd2;

    typedef enum logic [1:0] {
        OP_ZERO,
        OP_WRITE,
        OP_EDGE,
        OP_NEIGHBOR
    } op_t;

    localparam int OP_W = $bits(op_t);

    typedef struct packed {
        logic               edge_found;
        logic [INDEX_W-1:0] found_triangle;
        logic [VTX_W-1:0]   third_vertex;
        logic               first_edge_hit;
        logic [INDEX_W-1:0] first_neighbor;
        logic               second_edge_hit;
        logic [INDEX_W-1:0] second_neighbor;
        logic               third_edge_hit;
        logic [INDEX_W-1:0] third_neighbor;
    } res_t;

endpackage

>>> rtl/teas_if.sv
// Valid/ready channel interfaces: input items, results and the count register write.
// Depends on teas_pkg for field widths.
interface teas_item_if;
    logic                          valid;
    logic                          ready;
    logic [teas_pkg::FUNC_W-1:0]   func;
    logic [teas_pkg::INDEX_W-1:0]  tri_index;
    logic [teas_pkg::VTX_W-1:0]    vert_a;
    logic [teas_pkg::VTX_W-1:0]    vert_b;
    logic [teas_pkg::VTX_W-1:0]    vert_c;

    modport source (output valid, func, tri_index, vert_a, vert_b, vert_c, input ready);
    modport sink   (input valid, func, tri_index, vert_a, vert_b, vert_c, output ready);
endinterface

interface teas_result_if;
    logic                          valid;
    logic                          ready;
    logic                          edge_found;
    logic [teas_pkg::INDEX_W-1:0]  found_triangle;
    logic [teas_pkg::VTX_W-1:0]    third_vertex;
    logic                          first_edge_hit;
    logic [teas_pkg::INDEX_W-1:0]  first_neighbor;
    logic                          second_edge_hit;
    logic [teas_pkg::INDEX_W-1:0]  second_neighbor;
    logic                          third_edge_hit;
    logic [teas_pkg::INDEX_W-1:0]  third_neighbor;

    modport source (output valid, edge_found, found_triangle, third_vertex, first_edge_hit,
                    first_neighbor, second_edge_hit, second_neighbor, third_edge_hit,
                    third_neighbor, input ready);
    modport sink   (input valid, edge_found, found_triangle, third_vertex, first_edge_hit,
                    first_neighbor, second_edge_hit, second_neighbor, third_edge_hit,
                    third_neighbor, output ready);
endinterface

interface teas_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [teas_pkg::COUNT_W-1:0]  triangle_count;

    modport source (output valid, triangle_count, input ready);
    modport sink   (input valid, triangle_count, output ready);
endinterface

>>> rtl/teas_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module teas_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/teas_front.sv
// Front end: accepts item beats, decodes func and range-checks the index.
// Depends on teas_pkg and teas_if; pushes packed commands into the queue.
module teas_front #(
    parameter int MAX_TRIANGLES  = teas_pkg::MAX_TRIANGLES_DEF,
    parameter int VERTEX_ID_BITS = teas_pkg::VERTEX_ID_BITS_DEF
) (
    teas_item_if.sink                                   item,
    input  logic [$clog2(MAX_TRIANGLES + 1)-1:0]        scan_len,
    input  logic                                        q_full,
    output logic                                        push,
    output logic [teas_pkg::OP_W + (MAX_TRIANGLES > 1 ? $clog2(MAX_TRIANGLES) : 1)
                  + 3 * VERTEX_ID_BITS - 1:0]           cmd
);

    localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

    typedef logic [VERTEX_ID_BITS-1:0] vid_t;
    typedef logic [IDX_W-1:0]          slot_t;

    teas_pkg::op_t op;
    logic          write_ok;
    logic          nbr_ok;

    assign write_ok = 32'(item.tri_index) < 32'(MAX_TRIANGLES);
    assign nbr_ok   = 32'(item.tri_index) < 32'(scan_len);

    always_comb
    begin
        unique case (item.func)
            teas_pkg::FUNC_WRITE:    op = write_ok ? teas_pkg::OP_WRITE : teas_pkg::OP_ZERO;
            teas_pkg::FUNC_EDGE:     op = (scan_len != '0) ? teas_pkg::OP_EDGE
                                                           : teas_pkg::OP_ZERO;
            teas_pkg::FUNC_NEIGHBOR: op = nbr_ok ? teas_pkg::OP_NEIGHBOR : teas_pkg::OP_ZERO;
            default:                 op = teas_pkg::OP_ZERO;
        endcase
    end

    assign item.ready = !q_full;
    assign push       = item.valid && !q_full;
    assign cmd        = {op, slot_t'(item.tri_index), vid_t'(item.vert_a),
                         vid_t'(item.vert_b), vid_t'(item.vert_c)};

endmodule

>>> rtl/teas_fifo.sv
// Short command queue between the front end and the search engine.
// No dependencies.
module teas_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = cnt_reg == CNT_W'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/teas_back.sv
// Search engine: executes queued commands against the triangle RAM, one slot a cycle.
// Depends on teas_pkg, teas_if and teas_ram; holds the result output register.
module teas_back #(
    parameter int MAX_TRIANGLES  = teas_pkg::MAX_TRIANGLES_DEF,
    parameter int VERTEX_ID_BITS = teas_pkg::VERTEX_ID_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic [$clog2(MAX_TRIANGLES + 1)-1:0]        scan_len,
    input  logic [teas_pkg::OP_W + (MAX_TRIANGLES > 1 ? $clog2(MAX_TRIANGLES) : 1)
                  + 3 * VERTEX_ID_BITS - 1:0]           cmd,
    input  logic                                        q_empty,
    output logic                                        pop,
    teas_result_if.source                               result
);

    localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int LEN_W = $clog2(MAX_TRIANGLES + 1);
    localparam int VB    = VERTEX_ID_BITS;
    localparam int ENT_W = 3 * VB;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    typedef logic [VB-1:0]    vid_t;
    typedef logic [LEN_W-1:0] len_t;

    logic [teas_pkg::OP_W-1:0] h_op_bits;
    teas_pkg::op_t             h_op;
    logic [IDX_W-1:0]          h_slot;
    vid_t                      h_va, h_vb, h_vc;

    logic [1:0]       state_reg, state_next;
    teas_pkg::op_t    op_reg, op_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    vid_t             v0_reg, v0_next, v1_reg, v1_next, v2_reg, v2_next;
    len_t             rd_cnt_reg, rd_cnt_next;
    logic             pend_vld_reg, pend_vld_next;
    len_t             pend_tag_reg, pend_tag_next;
    teas_pkg::res_t   acc_reg, acc_next;
    logic             out_vld_reg, out_vld_next;
    teas_pkg::res_t   out_reg, out_next;

    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;
    vid_t             w0, w1, w2;
    logic [2:0][2:0]  eq;
    logic             e_hit;
    vid_t             e_rest;
    logic [2:0]       n_hit;
    logic             stop;

    function automatic logic has_edge(logic [2:0][2:0] m, int j, int k);
        return (m[0][j] && m[1][k]) || (m[1][j] && m[0][k]) ||
               (m[1][j] && m[2][k]) || (m[2][j] && m[1][k]) ||
               (m[0][j] && m[2][k]) || (m[2][j] && m[0][k]);
    endfunction

    assign {h_op_bits, h_slot, h_va, h_vb, h_vc} = cmd;
    assign h_op = teas_pkg::op_t'(h_op_bits);

    teas_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TRIANGLES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (h_slot),
        .wdata ({h_va, h_vb, h_vc}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign {w0, w1, w2} = mem_rdata;

    always_comb
    begin
        eq[0][0] = w0 == v0_reg;
        eq[0][1] = w0 == v1_reg;
        eq[0][2] = w0 == v2_reg;
        eq[1][0] = w1 == v0_reg;
        eq[1][1] = w1 == v1_reg;
        eq[1][2] = w1 == v2_reg;
        eq[2][0] = w2 == v0_reg;
        eq[2][1] = w2 == v1_reg;
        eq[2][2] = w2 == v2_reg;
    end

    // edge query: v0 is endpoint a, v1 is endpoint b
    always_comb
    begin
        e_hit  = 1'b0;
        e_rest = w2;
        if (eq[0][0])
        begin
            if (eq[1][1])
            begin
                e_hit  = 1'b1;
                e_rest = w2;
            end
            else if (eq[2][1])
            begin
                e_hit  = 1'b1;
                e_rest = w1;
            end
        end
        else if (eq[0][1])
        begin
            if (eq[1][0])
            begin
                e_hit  = 1'b1;
                e_rest = w2;
            end
            else if (eq[2][0])
            begin
                e_hit  = 1'b1;
                e_rest = w1;
            end
        end
        else if ((eq[1][0] && eq[2][1]) || (eq[1][1] && eq[2][0]))
        begin
            e_hit  = 1'b1;
            e_rest = w0;
        end
    end

    assign n_hit[0] = has_edge(eq, 0, 1);
    assign n_hit[1] = has_edge(eq, 1, 2);
    assign n_hit[2] = has_edge(eq, 2, 0);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        slot_next     = slot_reg;
        v0_next       = v0_reg;
        v1_next       = v1_reg;
        v2_next       = v2_reg;
        rd_cnt_next   = rd_cnt_reg;
        pend_vld_next = 1'b0;
        pend_tag_next = rd_cnt_reg;
        acc_next      = acc_reg;
        out_vld_next  = out_vld_reg && !result.ready;
        out_next      = out_reg;
        pop           = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = rd_cnt_reg[IDX_W-1:0];
        stop          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop         = 1'b1;
                    op_next     = h_op;
                    slot_next   = h_slot;
                    v0_next     = h_va;
                    v1_next     = h_vb;
                    rd_cnt_next = '0;
                    acc_next    = '0;
                    unique case (h_op)
                        teas_pkg::OP_WRITE:
                        begin
                            mem_we     = 1'b1;
                            state_next = S_DONE;
                        end
                        teas_pkg::OP_EDGE:
                        begin
                            state_next = S_SCAN;
                        end
                        teas_pkg::OP_NEIGHBOR:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = h_slot;
                            state_next = S_FETCH;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                v0_next    = w0;
                v1_next    = w1;
                v2_next    = w2;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (rd_cnt_reg < scan_len)
                begin
                    mem_re        = 1'b1;
                    rd_cnt_next   = rd_cnt_reg + len_t'(1);
                    pend_vld_next = 1'b1;
                end
                if (pend_vld_reg)
                begin
                    if (op_reg == teas_pkg::OP_EDGE)
                    begin
                        if (e_hit)
                        begin
                            acc_next.edge_found     = 1'b1;
                            acc_next.found_triangle = teas_pkg::INDEX_W'(pend_tag_reg);
                            acc_next.third_vertex   = teas_pkg::VTX_W'(e_rest);
                        end
                        stop = e_hit;
                    end
                    else
                    begin
                        if (pend_tag_reg != len_t'(slot_reg))
                        begin
                            if (n_hit[0])
                            begin
                                acc_next.first_edge_hit = 1'b1;
                                acc_next.first_neighbor = teas_pkg::INDEX_W'(pend_tag_reg);
                            end
                            if (n_hit[1])
                            begin
                                acc_next.second_edge_hit = 1'b1;
                                acc_next.second_neighbor = teas_pkg::INDEX_W'(pend_tag_reg);
                            end
                            if (n_hit[2])
                            begin
                                acc_next.third_edge_hit = 1'b1;
                                acc_next.third_neighbor = teas_pkg::INDEX_W'(pend_tag_reg);
                            end
                        end
                        stop = acc_next.first_edge_hit && acc_next.second_edge_hit &&
                               acc_next.third_edge_hit;
                    end
                end
                if (stop || (!pend_vld_reg && rd_cnt_reg == scan_len))
                begin
                    pend_vld_next = 1'b0;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    out_vld_next = 1'b1;
                    out_next     = acc_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        v0_reg       <= v0_next;
        v1_reg       <= v1_next;
        v2_reg       <= v2_next;
        rd_cnt_reg   <= rd_cnt_next;
        pend_tag_reg <= pend_tag_next;
        acc_reg      <= acc_next;
        out_reg      <= out_next;
    end

    assign result.valid           = out_vld_reg;
    assign result.edge_found      = out_reg.edge_found;
    assign result.found_triangle  = out_reg.found_triangle;
    assign result.third_vertex    = out_reg.third_vertex;
    assign result.first_edge_hit  = out_reg.first_edge_hit;
    assign result.first_neighbor  = out_reg.first_neighbor;
    assign result.second_edge_hit = out_reg.second_edge_hit;
    assign result.second_neighbor = out_reg.second_neighbor;
    assign result.third_edge_hit  = out_reg.third_edge_hit;
    assign result.third_neighbor  = out_reg.third_neighbor;

endmodule

>>> rtl/triangle_edge_adjacency_search.sv
// Edge and neighbor queries scan up to scan length = min(count, slots) triangle slots.
// Throughput: one item at a time in the search engine, one triangle slot per cycle through
// the RAM read port; the front end keeps accepting until its two-entry queue fills.
// Reset: control and the triangle_count register clear to 0; triangle RAM contents
// stay undefined until written, with no clearing pass.
module triangle_edge_adjacency_search #(
    parameter int MAX_TRIANGLES  = teas_pkg::MAX_TRIANGLES_DEF,
    parameter int VERTEX_ID_BITS = teas_pkg::VERTEX_ID_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    teas_item_if.sink     item,
    teas_result_if.source result,
    teas_cfg_if.sink      cfg
);

    localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int LEN_W = $clog2(MAX_TRIANGLES + 1);
    localparam int CMP_W = (teas_pkg::COUNT_W > LEN_W) ? teas_pkg::COUNT_W : LEN_W;
    localparam int CMD_W = teas_pkg::OP_W + IDX_W + 3 * VERTEX_ID_BITS;

    logic [teas_pkg::COUNT_W-1:0] triangle_count_reg, triangle_count_next;
    logic [CMP_W-1:0]             cnt_ext, max_ext;
    logic [LEN_W-1:0]             scan_len;
    logic                         push, pop, q_full, q_empty;
    logic [CMD_W-1:0]             push_cmd, head_cmd;

    assign cfg.ready           = 1'b1;
    assign triangle_count_next = (cfg.valid && cfg.ready) ? cfg.triangle_count
                                                          : triangle_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            triangle_count_reg <= '0;
        end
        else
        begin
            triangle_count_reg <= triangle_count_next;
        end
    end

    assign cnt_ext  = CMP_W'(triangle_count_reg);
    assign max_ext  = CMP_W'(MAX_TRIANGLES);
    assign scan_len = LEN_W'((cnt_ext > max_ext) ? max_ext : cnt_ext);

    teas_front #(
        .MAX_TRIANGLES  (MAX_TRIANGLES),
        .VERTEX_ID_BITS (VERTEX_ID_BITS)
    ) u_front (
        .item     (item),
        .scan_len (scan_len),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    teas_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (teas_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    teas_back #(
        .MAX_TRIANGLES  (MAX_TRIANGLES),
        .VERTEX_ID_BITS (VERTEX_ID_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_len (scan_len),
        .cmd      (head_cmd),
        .q_empty  (q_empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

>>> rtl/teas_checker.sv
// Port-level checks for triangle_edge_adjacency_search, bound to the top level.
// Depends on teas_pkg for field widths and queue depth.
module teas_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic                          edge_found,
    input logic [teas_pkg::INDEX_W-1:0]  found_triangle,
    input logic [teas_pkg::VTX_W-1:0]    third_vertex,
    input logic                          first_edge_hit,
    input logic [teas_pkg::INDEX_W-1:0]  first_neighbor,
    input logic                          second_edge_hit,
    input logic [teas_pkg::INDEX_W-1:0]  second_neighbor,
    input logic                          third_edge_hit,
    input logic [teas_pkg::INDEX_W-1:0]  third_neighbor
);

    localparam int MAX_OPEN = teas_pkg::QUEUE_DEPTH + 2;
    localparam int OPEN_W   = $clog2(MAX_OPEN + 2);

    logic [OPEN_W-1:0] open_reg, open_next;
    logic              in_beat, out_beat;

    assign in_beat  = item_valid && item_ready;
    assign out_beat = res_valid && res_ready;

    always_comb
    begin
        open_next = open_reg;
        if (in_beat && !out_beat)
        begin
            open_next = open_reg + OPEN_W'(1);
        end
        else if (out_beat && !in_beat)
        begin
            open_next = open_reg - OPEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> open_reg != '0)
        else $error("result beat without an outstanding item");

    a_open_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= OPEN_W'(MAX_OPEN))
        else $error("more items in flight than the block can hold");

    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && edge_found |-> !first_edge_hit && !second_edge_hit && !third_edge_hit)
        else $error("edge and neighbor results mixed in one beat");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !edge_found |-> found_triangle == '0 && third_vertex == '0)
        else $error("edge miss with nonzero index or vertex");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(edge_found) &&
        $stable(found_triangle) && $stable(third_vertex) && $stable(first_edge_hit) &&
        $stable(first_neighbor) && $stable(second_edge_hit) && $stable(second_neighbor) &&
        $stable(third_edge_hit) && $stable(third_neighbor))
        else $error("stalled result beat changed");

endmodule

bind triangle_edge_adjacency_search teas_checker u_teas_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .edge_found      (result.edge_found),
    .found_triangle  (result.found_triangle),
    .third_vertex    (result.third_vertex),
    .first_edge_hit  (result.first_edge_hit),
    .first_neighbor  (result.first_neighbor),
    .second_edge_hit (result.second_edge_hit),
    .second_neighbor (result.second_neighbor),
    .third_edge_hit  (result.third_edge_hit),
    .third_neighbor  (result.third_neighbor)
);
